FILE: src/class_pattern_stream_matcher_assert.svh
// Assertion macros for the matcher RTL.
`ifndef CLASS_PATTERN_STREAM_MATCHER_ASSERT_SVH
`define CLASS_PATTERN_STREAM_MATCHER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CPSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/cpsm_pkg.sv
package cpsm_pkg;

  // Default number of pattern symbols
  localparam int PATTERN_MAX_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_REG_W  = 5;

  // Character codes
  localparam logic [7:0] CHR_A_UP   = 8'h41;
  localparam logic [7:0] CHR_Z_UP   = 8'h5A;
  localparam logic [7:0] CHR_A_LO   = 8'h61;
  localparam logic [7:0] CHR_Z_LO   = 8'h7A;
  localparam logic [7:0] CHR_D_LO   = 8'h64;
  localparam logic [7:0] CHR_0      = 8'h30;
  localparam logic [7:0] CHR_9      = 8'h39;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_TAB    = 8'h09;
  localparam logic [7:0] CHR_LF     = 8'h0A;
  localparam logic [7:0] CHR_CR     = 8'h0D;
  localparam logic [7:0] CHR_QMARK  = 8'h3F;
  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_STAR   = 8'h2A;

  typedef enum logic [3:0] {
    MODE_NORMAL = 4'b0001,
    MODE_NLRUN  = 4'b0010,
    MODE_STAR   = 4'b0100,
    MODE_DONE   = 4'b1000
  } match_mode_t;

  // One text request
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_string;
  } text_item_t;

  function automatic logic is_crlf(input logic [7:0] b);
    return (b == CHR_LF) || (b == CHR_CR);
  endfunction

  // Test a byte against one symbol, by class or, for other symbols, by equality
  function automatic logic class_fits(input logic [7:0] b, input logic [7:0] s);
    logic upper;
    logic letter;
    logic digit;
    logic blank;
    logic fits;
    upper  = (b >= CHR_A_UP) && (b <= CHR_Z_UP);
    letter = upper || ((b >= CHR_A_LO) && (b <= CHR_Z_LO));
    digit  = (b >= CHR_0) && (b <= CHR_9);
    blank  = (b == CHR_SPACE) || (b == CHR_TAB);
    case (s)
      CHR_A_UP:   fits = upper;
      CHR_A_LO:   fits = letter;
      CHR_D_LO:   fits = digit;
      CHR_QMARK:  fits = 1'b1;
      CHR_SPACE:  fits = blank;
      CHR_LF:     fits = is_crlf(b);
      CHR_DOLLAR: fits = !(blank || is_crlf(b) || letter || digit);
      default:    fits = (b == s);
    endcase
    return fits;
  endfunction

endpackage

FILE: src/cpsm_cfg.sv
module cpsm_cfg
  import cpsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        wr_en,
  input  logic [CFG_IDX_W-1:0]        wr_index,
  input  logic [CFG_DATA_W-1:0]       wr_data,
  output logic [PATTERN_MAX-1:0][7:0] syms,
  output logic [LEN_REG_W-1:0]        pattern_length
);

  // Write pattern symbols and length
  always_ff @(posedge clk) begin
    if (rst) begin
      syms           <= '0;
      pattern_length <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_PATTERN_LOW: begin
          for (int i = 0; i < 8; i++) begin
            syms[i] <= wr_data[8*i +: 8];
          end
        end
        REG_PATTERN_HIGH: begin
          for (int i = 8; i < PATTERN_MAX; i++) begin
            syms[i] <= wr_data[8*(i-8) +: 8];
          end
        end
        REG_PATTERN_LEN: pattern_length <= wr_data[LEN_REG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/cpsm_core.sv
module cpsm_core
  import cpsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step_fire,
  input  text_item_t                  item,
  input  logic [PATTERN_MAX-1:0][7:0] syms,
  input  logic [LEN_REG_W-1:0]        pattern_length,
  output logic                        step_match
);

  localparam int PW = $clog2(PATTERN_MAX + 1);
  localparam int IW = $clog2(PATTERN_MAX);

  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  match_mode_t   mode;
  match_mode_t   mode_next;
  logic          decision;
  logic          decision_next;

  logic [PW-1:0] len;
  logic [PW-1:0] pos_inc;
  logic          adv_done;
  logic [7:0]    sym;
  logic [7:0]    b;
  match_mode_t   mode_chk;
  logic          dec_chk;
  match_mode_t   mode_step;
  logic          dec_step;
  logic [PW-1:0] pos_step;

  // Saturate length and pick the current symbol
  always_comb begin
    if (pattern_length > LEN_REG_W'(PATTERN_MAX)) begin
      len = PW'(PATTERN_MAX);
    end else begin
      len = pattern_length[PW-1:0];
    end
    if (pos < PW'(PATTERN_MAX)) begin
      sym = syms[pos[IW-1:0]];
    end else begin
      sym = '0;
    end
  end

  assign b        = item.text_byte;
  assign pos_inc  = pos + PW'(1);
  assign adv_done = (pos_inc >= len);

  // Advance over one byte
  always_comb begin
    mode_chk = mode;
    dec_chk  = decision;
    if ((mode != MODE_DONE) && (pos >= len)) begin
      mode_chk = MODE_DONE;
      dec_chk  = (len != '0);
    end

    pos_step  = pos;
    mode_step = mode_chk;
    dec_step  = dec_chk;
    if ((mode_chk == MODE_NLRUN) && is_crlf(b)) begin
      // stay inside the CR/LF run
    end else if (mode_chk == MODE_STAR) begin
      if (class_fits(b, sym)) begin
        pos_step  = pos_inc;
        mode_step = adv_done ? MODE_DONE : MODE_NORMAL;
        dec_step  = adv_done ? 1'b1 : dec_chk;
      end
    end else if (mode_chk != MODE_DONE) begin
      if (sym == CHR_LF) begin
        if (is_crlf(b)) begin
          pos_step  = pos_inc;
          mode_step = adv_done ? MODE_DONE : MODE_NLRUN;
          dec_step  = adv_done ? 1'b1 : dec_chk;
        end else begin
          mode_step = MODE_DONE;
          dec_step  = 1'b0;
        end
      end else if (sym == CHR_STAR) begin
        pos_step  = pos_inc;
        mode_step = adv_done ? MODE_DONE : MODE_STAR;
        dec_step  = adv_done ? 1'b1 : dec_chk;
      end else if (class_fits(b, sym)) begin
        pos_step  = pos_inc;
        mode_step = adv_done ? MODE_DONE : MODE_NORMAL;
        dec_step  = adv_done ? 1'b1 : dec_chk;
      end else begin
        mode_step = MODE_DONE;
        dec_step  = 1'b0;
      end
    end

    step_match = (mode_step == MODE_DONE) && dec_step;

    // Restart on the last byte of a string
    if (item.end_of_string) begin
      pos_next      = '0;
      mode_next     = MODE_NORMAL;
      decision_next = 1'b0;
    end else begin
      pos_next      = pos_step;
      mode_next     = mode_step;
      decision_next = dec_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      mode     <= MODE_NORMAL;
      decision <= 1'b0;
    end else if (step_fire) begin
      pos      <= pos_next;
      mode     <= mode_next;
      decision <= decision_next;
    end
  end

endmodule

FILE: src/class_pattern_stream_matcher.sv
// Prefix matcher for a byte stream against a class pattern of up to PATTERN_MAX
// symbols. One byte is taken per cycle, back to back, while in_stall is low; one
// request out (matched) appears for each byte flagged end_of_string, registered
// in the result register after the byte has passed the input register, and no
// request for other bytes. The rate is one byte per cycle while in_stall is low:
// the pattern state updates for one byte in short logic between the input
// register and the result register. in_stall rises only while the input register
// holds a byte and the result register holds a result that out_stall blocks.
// cfg_ready is always high; pattern_length above PATTERN_MAX counts as PATTERN_MAX.
`include "class_pattern_stream_matcher_assert.svh"

module class_pattern_stream_matcher
  import cpsm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_string,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  matched,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                        in_fire;
  logic                        proc_fire;
  logic                        item_valid;
  logic                        item_valid_next;
  text_item_t                  item;
  logic                        out_valid_next;
  logic                        step_match;
  logic [PATTERN_MAX-1:0][7:0] syms;
  logic [LEN_REG_W-1:0]        pattern_length;

  assign cfg_ready = 1'b1;

  cpsm_cfg #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_valid && cfg_ready),
    .wr_index      (cfg_index),
    .wr_data       (cfg_data),
    .syms          (syms),
    .pattern_length(pattern_length)
  );

  // Process the held byte unless the result register is blocked
  assign proc_fire = item_valid && !(out_valid && out_stall);
  assign in_stall  = item_valid && out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;

  assign item_valid_next = in_fire || (item_valid && !proc_fire);
  assign out_valid_next  = (out_valid && out_stall) || (proc_fire && item.end_of_string);

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= item_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item.text_byte     <= text_byte;
      item.end_of_string <= end_of_string;
    end
  end

  cpsm_core #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step_fire     (proc_fire),
    .item          (item),
    .syms          (syms),
    .pattern_length(pattern_length),
    .step_match    (step_match)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && item.end_of_string) begin
      matched <= step_match;
    end
  end

  `CPSM_ASSERT_IMP(a_stall_only_full, in_stall, item_valid && out_valid, "stall without full pipe")
  `CPSM_ASSERT_NEXT(a_eos_gives_result, proc_fire && item.end_of_string, out_valid, "result missing")
  `CPSM_ASSERT_NEXT(a_no_extra_result, proc_fire && !item.end_of_string && !out_valid, !out_valid, "spurious result")

endmodule
